@@ rtl/csrt_pkg.sv @@
// Shared types and field widths for the sparse CSR transpose engine.
// Used by sparse_csr_transpose_top and the bench; depends on nothing.

package csrt_pkg;

  // Fixed field widths of the stream words
  localparam int unsigned ROW_W   = 10;
  localparam int unsigned COL_W   = 10;
  localparam int unsigned VAL_W   = 64;
  localparam int unsigned SLOT_W  = 11;
  localparam int unsigned PTR_W   = 11;
  localparam int unsigned CFG_W   = 11;
  localparam int unsigned OP_W    = 3;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned IN_DW   = 96;
  localparam int unsigned OUT_DW  = 88;

  // Stored entry layouts: {value, col, row} and {value, row}
  localparam int unsigned LD_W = VAL_W + COL_W + ROW_W;
  localparam int unsigned TR_W = VAL_W + ROW_W;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 3'd0,
    OP_BUILD = 3'd1,
    OP_RDPTR = 3'd2,
    OP_RDENT = 3'd3,
    OP_CLEAR = 3'd4
  } csrt_op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_CAPACITY = 2'd1,
    ST_RANGE    = 2'd2,
    ST_BADSLOT  = 2'd3
  } csrt_status_e;

  typedef enum logic {
    REG_NUM_ROWS = 1'b0,
    REG_NUM_COLS = 1'b1
  } csrt_reg_e;

endpackage

@@ rtl/csrt_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package dependency.

module csrt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/sparse_csr_transpose_top.sv @@
// Sparse CSR transpose engine: loads nonzeros, builds the transposed CSR, serves reads,
// clears. Rejected items go straight to the output; a build sums the column counts,
// then scatters each stored entry. One item at a time. Each step is set by the
// registered read of the entry memories.
// Reset: async active low; a clearing pass zeroes the COLS_MAX column counts before
// the first word is taken. Depends on csrt_pkg and csrt_ram.

module sparse_csr_transpose_top #(
  parameter int unsigned ROWS_MAX = 1024,
  parameter int unsigned COLS_MAX = 1024,
  parameter int unsigned NNZ_MAX  = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_index_i,
  input  logic [csrt_pkg::CFG_W-1:0]    cfg_data_i,
  // Input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata: row_index[9:0], col_index[19:10], entry_value[83:20], read_slot[94:84]
  input  logic [csrt_pkg::IN_DW-1:0]    s_axis_tdata,
  // tuser: op[2:0]
  input  logic [csrt_pkg::OP_W-1:0]     s_axis_tuser,
  // Output stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // tdata: pointer_value[10:0], out_row[20:11], out_value[84:21]
  output logic [csrt_pkg::OUT_DW-1:0]   m_axis_tdata,
  // tuser: status[1:0]
  output logic [csrt_pkg::STAT_W-1:0]   m_axis_tuser
);

  localparam int unsigned NW = $clog2(NNZ_MAX + 1);
  localparam int unsigned CW = $clog2(COLS_MAX + 1);
  localparam int unsigned RW = $clog2(ROWS_MAX + 1);
  localparam int unsigned NA = (NNZ_MAX > 1) ? $clog2(NNZ_MAX) : 1;
  localparam int unsigned CA = (COLS_MAX > 1) ? $clog2(COLS_MAX) : 1;
  localparam int unsigned PA = $clog2(COLS_MAX + 2);
  localparam int unsigned ROW_W = csrt_pkg::ROW_W;
  localparam int unsigned COL_W = csrt_pkg::COL_W;
  localparam int unsigned VAL_W = csrt_pkg::VAL_W;
  localparam int unsigned LD_W  = csrt_pkg::LD_W;
  localparam int unsigned TR_W  = csrt_pkg::TR_W;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_LWR,
    S_PRD,
    S_PWR,
    S_SRD,
    S_SFR,
    S_SWR,
    S_RPTR,
    S_RENT,
    S_OUT
  } state_e;

  state_e state_q;

  // Input word fields
  logic [ROW_W-1:0]           in_row;
  logic [COL_W-1:0]           in_col;
  logic [VAL_W-1:0]           in_val;
  logic [csrt_pkg::SLOT_W-1:0] in_slot;
  csrt_pkg::csrt_op_e         in_op;

  assign in_row  = s_axis_tdata[9:0];
  assign in_col  = s_axis_tdata[19:10];
  assign in_val  = s_axis_tdata[83:20];
  assign in_slot = s_axis_tdata[94:84];
  assign in_op   = csrt_pkg::csrt_op_e'(s_axis_tuser);

  // Control and working registers
  logic [csrt_pkg::CFG_W-1:0] num_rows_q, num_cols_q;
  logic [CW-1:0]              cl_q;
  logic                       clr_op_q;
  logic [NW-1:0]              nz_q;
  logic                       built_q;
  logic [CW-1:0]              bcols_q, ncols_q, c_q;
  logic [NW-1:0]              bcount_q, acc_q, k_q;
  logic [COL_W-1:0]           col_q;
  logic [ROW_W-1:0]           row_q;
  logic [VAL_W-1:0]           val_q;
  csrt_pkg::csrt_status_e     res_status_q, m_status_q;
  logic [csrt_pkg::PTR_W-1:0] res_ptr_q, m_ptr_q;
  logic [ROW_W-1:0]           res_row_q, m_row_q;
  logic [VAL_W-1:0]           res_val_q, m_val_q;
  logic                       m_valid_q;

  // Clamped limits
  logic [RW-1:0] rows_lim;
  logic [CW-1:0] cols_lim;

  assign rows_lim = (32'(num_rows_q) > ROWS_MAX) ? RW'(ROWS_MAX) : RW'(num_rows_q);
  assign cols_lim = (32'(num_cols_q) > COLS_MAX) ? CW'(COLS_MAX) : CW'(num_cols_q);

  logic in_acc, ld_range_bad, ld_full, rp_ok, tr_ok;

  assign in_acc       = s_axis_tvalid && s_axis_tready;
  assign ld_range_bad = (32'(in_row) >= 32'(rows_lim)) || (32'(in_col) >= 32'(cols_lim));
  assign ld_full      = (32'(nz_q) >= NNZ_MAX);
  assign rp_ok        = built_q && (32'(in_slot) <= 32'(bcols_q));
  assign tr_ok        = built_q && (32'(in_slot) < 32'(bcount_q));

  // Memory ports
  logic            ld_we, ld_re;
  logic [NA-1:0]   ld_waddr, ld_raddr;
  logic [LD_W-1:0] ld_wdata, ld_rdata;
  logic            cnt_we, cnt_re;
  logic [CA-1:0]   cnt_waddr, cnt_raddr;
  logic [NW-1:0]   cnt_wdata, cnt_rdata;
  logic            rp_we, rp_re;
  logic [PA-1:0]   rp_waddr, rp_raddr;
  logic [NW-1:0]   rp_wdata, rp_rdata;
  logic            fo_we, fo_re;
  logic [CA-1:0]   fo_waddr, fo_raddr;
  logic [NW-1:0]   fo_wdata, fo_rdata;
  logic            tr_we, tr_re;
  logic [NA-1:0]   tr_waddr, tr_raddr;
  logic [TR_W-1:0] tr_wdata, tr_rdata;

  logic [ROW_W-1:0] ldr_row;
  logic [COL_W-1:0] ldr_col;
  logic [VAL_W-1:0] ldr_val;
  logic [NW-1:0]    acc_sum;

  assign ldr_row = ld_rdata[9:0];
  assign ldr_col = ld_rdata[19:10];
  assign ldr_val = ld_rdata[83:20];
  assign acc_sum = acc_q + cnt_rdata;

  // Memory port steering by state
  always_comb begin
    ld_we = 1'b0; ld_waddr = NA'(nz_q); ld_wdata = {in_val, in_col, in_row};
    ld_re = 1'b0; ld_raddr = NA'(k_q);
    cnt_we = 1'b0; cnt_waddr = CA'(cl_q); cnt_wdata = '0;
    cnt_re = 1'b0; cnt_raddr = CA'(in_col);
    rp_we = 1'b0; rp_waddr = '0; rp_wdata = '0;
    rp_re = 1'b0; rp_raddr = PA'(in_slot);
    fo_we = 1'b0; fo_waddr = CA'(c_q); fo_wdata = acc_q;
    fo_re = 1'b0; fo_raddr = CA'(ldr_col);
    tr_we = 1'b0; tr_waddr = NA'(fo_rdata); tr_wdata = {val_q, row_q};
    tr_re = 1'b0; tr_raddr = NA'(in_slot);
    case (state_q)
      S_CLR: begin
        cnt_we = 1'b1;
      end
      S_IDLE: begin
        if (in_acc) begin
          case (in_op)
            csrt_pkg::OP_LOAD: begin
              if (!ld_range_bad && !ld_full) begin
                ld_we  = 1'b1;
                cnt_re = 1'b1;
              end
            end
            csrt_pkg::OP_BUILD: begin
              rp_we = 1'b1;
            end
            csrt_pkg::OP_RDPTR: rp_re = rp_ok;
            csrt_pkg::OP_RDENT: tr_re = tr_ok;
            default: ;
          endcase
        end
      end
      S_LWR: begin
        cnt_we    = 1'b1;
        cnt_waddr = CA'(col_q);
        cnt_wdata = cnt_rdata + NW'(1);
      end
      S_PRD: begin
        cnt_re    = 1'b1;
        cnt_raddr = CA'(c_q);
      end
      S_PWR: begin
        rp_we    = 1'b1;
        rp_waddr = PA'(32'(c_q) + 1);
        rp_wdata = acc_sum;
        fo_we    = 1'b1;
      end
      S_SRD: begin
        ld_re = (k_q != nz_q);
      end
      S_SFR: begin
        fo_re = (32'(ldr_col) < 32'(ncols_q));
      end
      S_SWR: begin
        tr_we    = 1'b1;
        fo_we    = 1'b1;
        fo_waddr = CA'(col_q);
        fo_wdata = fo_rdata + NW'(1);
      end
      default: ;
    endcase
  end

  csrt_ram #(.WIDTH(LD_W), .DEPTH(NNZ_MAX)) u_ld_ram (
    .clk_i, .we_i(ld_we), .waddr_i(ld_waddr), .wdata_i(ld_wdata),
    .re_i(ld_re), .raddr_i(ld_raddr), .rdata_o(ld_rdata)
  );

  csrt_ram #(.WIDTH(NW), .DEPTH(COLS_MAX)) u_cnt_ram (
    .clk_i, .we_i(cnt_we), .waddr_i(cnt_waddr), .wdata_i(cnt_wdata),
    .re_i(cnt_re), .raddr_i(cnt_raddr), .rdata_o(cnt_rdata)
  );

  csrt_ram #(.WIDTH(NW), .DEPTH(COLS_MAX + 1)) u_rp_ram (
    .clk_i, .we_i(rp_we), .waddr_i(rp_waddr), .wdata_i(rp_wdata),
    .re_i(rp_re), .raddr_i(rp_raddr), .rdata_o(rp_rdata)
  );

  csrt_ram #(.WIDTH(NW), .DEPTH(COLS_MAX)) u_fo_ram (
    .clk_i, .we_i(fo_we), .waddr_i(fo_waddr), .wdata_i(fo_wdata),
    .re_i(fo_re), .raddr_i(fo_raddr), .rdata_o(fo_rdata)
  );

  csrt_ram #(.WIDTH(TR_W), .DEPTH(NNZ_MAX)) u_tr_ram (
    .clk_i, .we_i(tr_we), .waddr_i(tr_waddr), .wdata_i(tr_wdata),
    .re_i(tr_re), .raddr_i(tr_raddr), .rdata_o(tr_rdata)
  );

  // Sequencer, configuration registers and output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLR;
      num_rows_q   <= csrt_pkg::CFG_W'(1024);
      num_cols_q   <= csrt_pkg::CFG_W'(1024);
      cl_q         <= '0;
      clr_op_q     <= 1'b0;
      nz_q         <= '0;
      built_q      <= 1'b0;
      bcols_q      <= '0;
      bcount_q     <= '0;
      ncols_q      <= '0;
      c_q          <= '0;
      acc_q        <= '0;
      k_q          <= '0;
      col_q        <= '0;
      row_q        <= '0;
      val_q        <= '0;
      res_status_q <= csrt_pkg::ST_OK;
      res_ptr_q    <= '0;
      res_row_q    <= '0;
      res_val_q    <= '0;
      m_valid_q    <= 1'b0;
      m_status_q   <= csrt_pkg::ST_OK;
      m_ptr_q      <= '0;
      m_row_q      <= '0;
      m_val_q      <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (csrt_pkg::csrt_reg_e'(cfg_index_i))
          csrt_pkg::REG_NUM_ROWS: num_rows_q <= cfg_data_i;
          csrt_pkg::REG_NUM_COLS: num_cols_q <= cfg_data_i;
          default: ;
        endcase
      end

      // Output word taken; S_OUT handles its own hand-off
      if (m_axis_tready && (state_q != S_OUT)) begin
        m_valid_q <= 1'b0;
      end

      case (state_q)
        // Zero the column counts one entry a cycle
        S_CLR: begin
          cl_q <= cl_q + CW'(1);
          if (32'(cl_q) + 1 >= COLS_MAX) begin
            cl_q     <= '0;
            clr_op_q <= 1'b0;
            state_q  <= clr_op_q ? S_OUT : S_IDLE;
          end
        end

        S_IDLE: begin
          if (in_acc) begin
            res_status_q <= csrt_pkg::ST_OK;
            res_ptr_q    <= '0;
            res_row_q    <= '0;
            res_val_q    <= '0;
            col_q        <= in_col;
            case (in_op)
              csrt_pkg::OP_LOAD: begin
                if (ld_range_bad) begin
                  res_status_q <= csrt_pkg::ST_RANGE;
                  state_q      <= S_OUT;
                end else if (ld_full) begin
                  res_status_q <= csrt_pkg::ST_CAPACITY;
                  state_q      <= S_OUT;
                end else begin
                  state_q <= S_LWR;
                end
              end
              csrt_pkg::OP_BUILD: begin
                ncols_q <= cols_lim;
                c_q     <= '0;
                acc_q   <= '0;
                k_q     <= '0;
                state_q <= (cols_lim == '0) ? S_SRD : S_PRD;
              end
              csrt_pkg::OP_RDPTR: begin
                if (rp_ok) begin
                  state_q <= S_RPTR;
                end else begin
                  res_status_q <= csrt_pkg::ST_BADSLOT;
                  state_q      <= S_OUT;
                end
              end
              csrt_pkg::OP_RDENT: begin
                if (tr_ok) begin
                  state_q <= S_RENT;
                end else begin
                  res_status_q <= csrt_pkg::ST_BADSLOT;
                  state_q      <= S_OUT;
                end
              end
              csrt_pkg::OP_CLEAR: begin
                nz_q     <= '0;
                built_q  <= 1'b0;
                bcols_q  <= '0;
                bcount_q <= '0;
                cl_q     <= '0;
                clr_op_q <= 1'b1;
                state_q  <= S_CLR;
              end
              default: ;
            endcase
          end
        end

        // Count update for an accepted load
        S_LWR: begin
          nz_q    <= nz_q + NW'(1);
          state_q <= S_OUT;
        end

        // Prefix sum over column counts
        S_PRD: begin
          state_q <= S_PWR;
        end

        S_PWR: begin
          acc_q <= acc_sum;
          c_q   <= c_q + CW'(1);
          if (32'(c_q) + 1 == 32'(ncols_q)) begin
            state_q <= S_SRD;
          end else begin
            state_q <= S_PRD;
          end
        end

        // Scatter stored entries in arrival order
        S_SRD: begin
          if (k_q == nz_q) begin
            built_q   <= 1'b1;
            bcols_q   <= ncols_q;
            bcount_q  <= acc_q;
            res_ptr_q <= csrt_pkg::PTR_W'(acc_q);
            state_q   <= S_OUT;
          end else begin
            state_q <= S_SFR;
          end
        end

        S_SFR: begin
          col_q <= ldr_col;
          row_q <= ldr_row;
          val_q <= ldr_val;
          if (32'(ldr_col) < 32'(ncols_q)) begin
            state_q <= S_SWR;
          end else begin
            k_q     <= k_q + NW'(1);
            state_q <= S_SRD;
          end
        end

        S_SWR: begin
          k_q     <= k_q + NW'(1);
          state_q <= S_SRD;
        end

        S_RPTR: begin
          res_ptr_q <= csrt_pkg::PTR_W'(rp_rdata);
          state_q   <= S_OUT;
        end

        S_RENT: begin
          res_row_q <= tr_rdata[9:0];
          res_val_q <= tr_rdata[73:10];
          state_q   <= S_OUT;
        end

        // Hand the result word to the output register once it is free
        S_OUT: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q  <= 1'b1;
            m_status_q <= res_status_q;
            m_ptr_q    <= res_ptr_q;
            m_row_q    <= res_row_q;
            m_val_q    <= res_val_q;
            state_q    <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {3'b000, m_val_q, m_row_q, m_ptr_q};
  assign m_axis_tuser  = m_status_q;

endmodule

@@ bench/csrt_checker.sv @@
// Checker for the sparse CSR transpose engine: watches the config and stream channels,
// keeps its own copy of the transpose state, and compares every output word.
// Depends on csrt_pkg.

module csrt_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic                          cfg_index_i,
  input  logic [csrt_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic                          s_tvalid_i,
  input  logic                          s_tready_i,
  input  logic [csrt_pkg::IN_DW-1:0]    s_tdata_i,
  input  logic [csrt_pkg::OP_W-1:0]     s_tuser_i,
  input  logic                          m_tvalid_i,
  input  logic                          m_tready_i,
  input  logic [csrt_pkg::OUT_DW-1:0]   m_tdata_i,
  input  logic [csrt_pkg::STAT_W-1:0]   m_tuser_i,
  output int                            fail_o,
  output int                            pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import csrt_pkg::*;

  localparam int unsigned NCOL = 1024;
  localparam int unsigned NNZ  = 1024;
  localparam int unsigned NROW = 1024;

  typedef struct packed {
    csrt_status_e       status;
    logic [PTR_W-1:0]   ptr;
    logic [ROW_W-1:0]   row;
    logic [VAL_W-1:0]   val;
  } csrt_result_t;

  // Shadow copy of the engine state
  logic [CFG_W-1:0]  rows_reg, cols_reg;
  logic [ROW_W-1:0]  ld_row [NNZ];
  logic [COL_W-1:0]  ld_col [NNZ];
  logic [VAL_W-1:0]  ld_val [NNZ];
  logic [PTR_W-1:0]  col_cnt [NCOL];
  logic [PTR_W-1:0]  row_ptr [NCOL+1];
  logic [PTR_W-1:0]  fill_ofs [NCOL];
  logic [ROW_W-1:0]  tr_row [NNZ];
  logic [VAL_W-1:0]  tr_val [NNZ];
  logic [PTR_W-1:0]  nnz_cnt;
  logic              is_built;
  logic [PTR_W-1:0]  built_cols, built_cnt;

  csrt_result_t result_q[$];
  int fails;

  function automatic logic [CFG_W-1:0] clamp(logic [CFG_W-1:0] v, int unsigned bound);
    return (v > bound) ? CFG_W'(bound) : v;
  endfunction

  // Prefix sum over column counts, then scatter in arrival order
  function automatic void build_transpose();
    logic [CFG_W-1:0] ncols;
    logic [PTR_W:0]   pos;
    ncols = clamp(cols_reg, NCOL);
    row_ptr[0] = '0;
    for (int c = 0; c < ncols; c++) begin
      row_ptr[c+1] = row_ptr[c] + col_cnt[c];
      fill_ofs[c] = '0;
    end
    for (int k = 0; k < nnz_cnt && k < NNZ; k++) begin
      if (ld_col[k] < ncols) begin
        pos = row_ptr[ld_col[k]] + fill_ofs[ld_col[k]];
        if (pos < NNZ) begin
          tr_row[pos] = ld_row[k];
          tr_val[pos] = ld_val[k];
        end
        fill_ofs[ld_col[k]] = fill_ofs[ld_col[k]] + 1'b1;
      end
    end
    is_built   = 1'b1;
    built_cols = ncols;
    built_cnt  = row_ptr[ncols];
  endfunction

  // Expected output word for one accepted input word; returns 0 when none
  function automatic bit predict_word(input logic [OP_W-1:0] op,
                                      input logic [IN_DW-1:0] d,
                                      output csrt_result_t r);
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [VAL_W-1:0]  val;
    logic [SLOT_W-1:0] slot;
    row  = d[9:0];
    col  = d[19:10];
    val  = d[83:20];
    slot = d[94:84];
    r = '{status: ST_OK, ptr: '0, row: '0, val: '0};
    case (op)
      OP_LOAD: begin
        if (row >= clamp(rows_reg, NROW) || col >= clamp(cols_reg, NCOL)) begin
          r.status = ST_RANGE;
        end else if (nnz_cnt >= NNZ) begin
          r.status = ST_CAPACITY;
        end else begin
          ld_row[nnz_cnt] = row;
          ld_col[nnz_cnt] = col;
          ld_val[nnz_cnt] = val;
          col_cnt[col] = col_cnt[col] + 1'b1;
          nnz_cnt = nnz_cnt + 1'b1;
        end
      end
      OP_BUILD: begin
        build_transpose();
        r.ptr = built_cnt;
      end
      OP_RDPTR: begin
        if (is_built && slot <= built_cols) r.ptr = row_ptr[slot];
        else r.status = ST_BADSLOT;
      end
      OP_RDENT: begin
        if (is_built && slot < built_cnt && slot < NNZ) begin
          r.row = tr_row[slot];
          r.val = tr_val[slot];
        end else begin
          r.status = ST_BADSLOT;
        end
      end
      OP_CLEAR: begin
        for (int c = 0; c < NCOL; c++) col_cnt[c] = '0;
        nnz_cnt    = '0;
        is_built   = 1'b0;
        built_cols = '0;
        built_cnt  = '0;
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  // Watch all channels at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    csrt_result_t exp_r, got_r;
    if (!rst_ni) begin
      rows_reg   = CFG_W'(NROW);
      cols_reg   = CFG_W'(NCOL);
      for (int c = 0; c < NCOL; c++) col_cnt[c] = '0;
      nnz_cnt    = '0;
      is_built   = 1'b0;
      built_cols = '0;
      built_cnt  = '0;
      result_q.delete();
      fails      = 0;
      fail_o    <= 0;
      pending_o <= 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got_r = '{status: csrt_status_e'(m_tuser_i), ptr: m_tdata_i[10:0],
                  row: m_tdata_i[20:11], val: m_tdata_i[84:21]};
        if (result_q.size() == 0) begin
          $display("%0t: output word with none expected: status %0d ptr %0d row %0d val %h",
                   $time, got_r.status, got_r.ptr, got_r.row, got_r.val);
          fails++;
        end else begin
          exp_r = result_q.pop_front();
          if (got_r.status !== exp_r.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_r.status, got_r.status);
            fails++;
          end
          if (got_r.ptr !== exp_r.ptr) begin
            $display("%0t: pointer expected %0d actual %0d", $time, exp_r.ptr, got_r.ptr);
            fails++;
          end
          if (got_r.row !== exp_r.row) begin
            $display("%0t: row expected %0d actual %0d", $time, exp_r.row, got_r.row);
            fails++;
          end
          if (got_r.val !== exp_r.val) begin
            $display("%0t: value expected %h actual %h", $time, exp_r.val, got_r.val);
            fails++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (csrt_reg_e'(cfg_index_i) == REG_NUM_ROWS) rows_reg = cfg_data_i;
        else cols_reg = cfg_data_i;
      end
      if (s_tvalid_i && s_tready_i) begin
        if (predict_word(s_tuser_i, s_tdata_i, exp_r)) result_q.push_back(exp_r);
      end
      fail_o    <= fails;
      pending_o <= result_q.size();
    end
  end

endmodule

@@ bench/tb_sparse_csr_transpose_top.sv @@
// Testbench top for sparse_csr_transpose_top: directed and random matrices, config
// sweeps and idle patterns on both streams. Depends on csrt_pkg and csrt_checker.

module tb_sparse_csr_transpose_top;
  timeunit 1ns;
  timeprecision 1ps;
  import csrt_pkg::*;

  localparam int STALL_LIMIT = 30000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid = 1'b0, cfg_ready, cfg_index = 1'b0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0, s_tready;
  logic [IN_DW-1:0] s_tdata = '0;
  logic [OP_W-1:0] s_tuser = '0;
  logic m_tvalid, m_tready = 1'b0;
  logic [OUT_DW-1:0] m_tdata;
  logic [STAT_W-1:0] m_tuser;
  int fail_cnt, pending_cnt;
  int tx_idle = 7, rx_idle = 88;
  int stall_cnt = 0, word_cnt = 0, matrix_cnt = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  sparse_csr_transpose_top dut (
    .clk_i, .rst_ni,
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready),
    .s_axis_tdata(s_tdata), .s_axis_tuser(s_tuser),
    .m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready),
    .m_axis_tdata(m_tdata), .m_axis_tuser(m_tuser)
  );

  csrt_checker u_checker (
    .clk_i, .rst_ni,
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .s_tvalid_i(s_tvalid), .s_tready_i(s_tready), .s_tdata_i(s_tdata), .s_tuser_i(s_tuser),
    .m_tvalid_i(m_tvalid), .m_tready_i(m_tready), .m_tdata_i(m_tdata), .m_tuser_i(m_tuser),
    .fail_o(fail_cnt), .pending_o(pending_cnt)
  );

  // Receiver backpressure
  always @(negedge clk_i) m_tready <= ($urandom_range(99) >= rx_idle);

  // Watchdog: cycles with no word accepted on any channel
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      stall_cnt <= 0;
    else
      stall_cnt <= stall_cnt + 1;
  end

  initial begin
    wait (stall_cnt >= STALL_LIMIT);
    $display("%0t: watchdog expired", $time);
    $display("status: fail");
    $finish;
  end

  task automatic send_word(input csrt_op_e op, input logic [ROW_W-1:0] row,
                           input logic [COL_W-1:0] col, input logic [VAL_W-1:0] val,
                           input logic [SLOT_W-1:0] slot);
    send_raw(op, row, col, val, slot);
  endtask

  task automatic send_raw(input logic [OP_W-1:0] op, input logic [ROW_W-1:0] row,
                          input logic [COL_W-1:0] col, input logic [VAL_W-1:0] val,
                          input logic [SLOT_W-1:0] slot);
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {1'b0, slot, val, col, row};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    word_cnt++;
  endtask

  // Stop sending and wait for every expected word, plus settling margin
  task automatic drain();
    @(negedge clk_i);
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input csrt_reg_e idx, input logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [VAL_W-1:0] rand_val();
    return {$urandom, $urandom};
  endfunction

  // One random matrix: configure, clear, load row-major with noise, build, read back
  task automatic run_matrix(input int nrows, input int ncols, input int nload, input int nread);
    int eff_r, eff_c, cur_row, pick;
    logic [SLOT_W-1:0] slot;
    eff_r = (nrows == 0) ? 1 : ((nrows > 1024) ? 1024 : nrows);
    eff_c = (ncols == 0) ? 1 : ((ncols > 1024) ? 1024 : ncols);
    cur_row = 0;
    drain();
    write_reg(REG_NUM_ROWS, CFG_W'(nrows));
    write_reg(REG_NUM_COLS, CFG_W'(ncols));
    matrix_cnt++;
    send_word(OP_CLEAR, '0, '0, '0, '0);
    for (int i = 0; i < nload; i++) begin
      pick = $urandom_range(99);
      if (pick < 3) begin
        send_raw(OP_W'($urandom_range(5, 7)), ROW_W'($urandom), COL_W'($urandom),
                 rand_val(), SLOT_W'($urandom));
      end else if (pick < 6) begin
        send_word(($urandom_range(1) != 0) ? OP_RDPTR : OP_RDENT, '0, '0, '0,
                  SLOT_W'($urandom));
      end else if (pick < 14) begin
        send_word(OP_LOAD, ROW_W'($urandom), COL_W'($urandom), rand_val(),
                  SLOT_W'($urandom));
      end else begin
        if ($urandom_range(3) == 0 && cur_row < eff_r - 1) cur_row++;
        send_word(OP_LOAD, ROW_W'(cur_row), COL_W'($urandom_range(eff_c - 1)),
                  rand_val(), SLOT_W'($urandom));
      end
    end
    send_word(OP_BUILD, ROW_W'($urandom), COL_W'($urandom), rand_val(), SLOT_W'($urandom));
    for (int i = 0; i < nread; i++) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        slot = SLOT_W'($urandom_range(eff_c + 1));
        send_word(OP_RDPTR, ROW_W'($urandom), COL_W'($urandom), rand_val(), slot);
      end else if (pick < 85) begin
        slot = SLOT_W'($urandom_range(nload + 1));
        send_word(OP_RDENT, ROW_W'($urandom), COL_W'($urandom), rand_val(), slot);
      end else if (pick < 95) begin
        send_word(($urandom_range(1) != 0) ? OP_RDPTR : OP_RDENT, ROW_W'($urandom),
                  COL_W'($urandom), rand_val(), SLOT_W'($urandom));
      end else begin
        send_word(OP_LOAD, ROW_W'($urandom_range(eff_r - 1)),
                  COL_W'($urandom_range(eff_c - 1)), rand_val(), SLOT_W'($urandom));
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reads before build, unused ops, extreme fields, full-size build
    send_word(OP_RDPTR, '0, '0, '0, '0);
    send_word(OP_RDENT, '0, '0, '0, '0);
    send_raw(3'd5, '1, '1, '1, '1);
    send_raw(3'd7, '0, '0, '0, '0);
    send_word(OP_LOAD, 10'd1023, 10'd1023, '1, '1);
    send_word(OP_LOAD, '0, '0, '0, '0);
    send_word(OP_LOAD, 10'd512, 10'd1, 64'h8000_0000_0000_0001, '0);
    send_word(OP_BUILD, '0, '0, '0, '0);
    send_word(OP_RDPTR, '0, '0, '0, 11'd0);
    send_word(OP_RDPTR, '0, '0, '0, 11'd2);
    send_word(OP_RDPTR, '0, '0, '0, 11'd1024);
    send_word(OP_RDPTR, '0, '0, '0, 11'd1025);
    send_word(OP_RDENT, '0, '0, '0, 11'd0);
    send_word(OP_RDENT, '0, '0, '0, 11'd2);
    send_word(OP_RDENT, '0, '0, '0, 11'd3);
    send_word(OP_RDENT, '0, '0, '0, 11'd2047);
    send_word(OP_CLEAR, '0, '0, '0, '0);
    send_word(OP_RDPTR, '0, '0, '0, '0);
    // Zero rows rejects every load; oversize columns act as the bound
    drain();
    write_reg(REG_NUM_ROWS, '0);
    write_reg(REG_NUM_COLS, 11'd2047);
    send_word(OP_LOAD, '0, '0, 64'h1, '0);
    // Columns shrunk after loading leaves the upper columns out
    drain();
    write_reg(REG_NUM_ROWS, 11'd1024);
    write_reg(REG_NUM_COLS, 11'd16);
    send_word(OP_LOAD, 10'd0, 10'd9, 64'h99, '0);
    send_word(OP_LOAD, 10'd1, 10'd2, 64'h22, '0);
    drain();
    write_reg(REG_NUM_COLS, 11'd4);
    send_word(OP_BUILD, '0, '0, '0, '0);
    send_word(OP_RDPTR, '0, '0, '0, 11'd4);
    send_word(OP_RDENT, '0, '0, '0, 11'd0);

    // Random matrices under three idle profiles
    tx_idle = 7;  rx_idle = 88;
    run_matrix(1, 1, 10, 10);
    run_matrix(8, 5, 40, 30);
    run_matrix(1024, 64, 50, 40);
    tx_idle = 88; rx_idle = 7;
    run_matrix(2047, 1024, 40, 30);
    run_matrix(30, 12, 40, 30);
    run_matrix(0, 8, 15, 10);
    tx_idle = 0;  rx_idle = 0;
    run_matrix(1024, 1, 30, 20);
    run_matrix(300, 20, 60, 40);
    run_matrix(16, 8, 100, 30);
    run_matrix(2, 1024, 20, 20);
    run_matrix(700, 32, 80, 60);
    drain();

    $display("covered %0d input words over %0d random matrices, row and column limits",
             word_cnt, matrix_cnt);
    $display("from zero to above the bound, unused ops, bad slots and column shrink");
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
